// ===== hw/rtl/wgis_pkg.sv =====
// Package with shared constants and types for the weight-group inclusion similarity block.
`timescale 1ns / 1ps
`default_nettype none
package wgis_pkg;

    localparam int Q_DEPTH = 256;
    localparam int D_DEPTH = 1024;
    localparam int Q_AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int D_AW = (D_DEPTH > 1) ? $clog2(D_DEPTH) : 1;
    localparam int Q_CW = $clog2(Q_DEPTH + 1);
    localparam int D_CW = $clog2(D_DEPTH + 1);
    localparam int SUM_W = 16 + Q_CW;
    localparam int PROD_W = SUM_W + 16;
    localparam int SIM_W = 40;
    localparam int FQ_DEPTH = 2;
    localparam int FQ_AW = 1;
    localparam int FQ_CW = 2;

    localparam logic [1:0] OP_QLOAD = 2'd0;
    localparam logic [1:0] OP_DLOAD = 2'd1;
    localparam logic [1:0] OP_EVAL = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic signed [15:0] TW_RESET = 16'sd256;
    localparam logic signed [63:0] SIM_MAX = 64'sd549755813887;
    localparam logic signed [63:0] SIM_MIN = -64'sd549755813888;

    typedef struct packed {
        logic [1:0] kind;
        logic [31:0] concept;
        logic signed [15:0] weight;
    } cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wgis_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module wgis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/wgis_front.sv =====
// Front end: accepts input transfers, classifies them and queues commands.
`timescale 1ns / 1ps
`default_nettype none
module wgis_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          opcode,
    input  wire logic [31:0]         concept_id,
    input  wire logic signed [15:0]  term_weight,
    output logic                     cmd_valid,
    output wgis_pkg::cmd_t           cmd,
    input  wire logic                cmd_pop
);

    wgis_pkg::cmd_t fifo_reg [wgis_pkg::FQ_DEPTH];
    logic [wgis_pkg::FQ_AW-1:0] wptr_reg, wptr_next;
    logic [wgis_pkg::FQ_AW-1:0] rptr_reg, rptr_next;
    logic [wgis_pkg::FQ_CW-1:0] cnt_reg, cnt_next;
    logic push, pop;

    assign in_stall = (cnt_reg == wgis_pkg::FQ_CW'(wgis_pkg::FQ_DEPTH));
    assign push = in_valid && !in_stall && (opcode != wgis_pkg::OP_NONE);
    assign cmd_valid = (cnt_reg != '0);
    assign pop = cmd_pop && cmd_valid;
    assign cmd = fifo_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wptr_reg] <= '{kind: opcode, concept: concept_id, weight: term_weight};
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/wgis_back.sv =====
// Back end: store loads and the evaluate walk with the result register.
`timescale 1ns / 1ps
`default_nettype none
module wgis_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_valid,
    input  wire wgis_pkg::cmd_t             cmd,
    output logic                            cmd_pop,
    input  wire logic signed [15:0]         tw,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed [39:0]              similarity,
    output logic                            overflowed
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_K_RD  = 4'd1;
    localparam logic [3:0] S_K_LAT = 4'd2;
    localparam logic [3:0] S_J_RD  = 4'd3;
    localparam logic [3:0] S_J_CMP = 4'd4;
    localparam logic [3:0] S_I_RD  = 4'd5;
    localparam logic [3:0] S_I_LAT = 4'd6;
    localparam logic [3:0] S_M_RD  = 4'd7;
    localparam logic [3:0] S_M_CMP = 4'd8;
    localparam logic [3:0] S_MUL   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [wgis_pkg::Q_CW-1:0] qcnt_reg, qcnt_next;
    logic [wgis_pkg::D_CW-1:0] dcnt_reg, dcnt_next;
    logic drop_reg, drop_next;
    logic [wgis_pkg::Q_CW-1:0] k_reg, k_next;
    logic [wgis_pkg::Q_CW-1:0] i_reg, i_next;
    logic [wgis_pkg::Q_CW-1:0] jm_reg, jm_next;
    logic [wgis_pkg::D_CW-1:0] jd_reg, jd_next;
    logic found_reg, found_next;
    logic first_reg, first_next;
    logic incl_reg, incl_next;
    logic [31:0] qc_reg, qc_next;
    logic signed [15:0] wi_reg, wi_next;
    logic signed [wgis_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic signed [wgis_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic out_valid_reg, out_valid_next;
    logic signed [39:0] sim_reg, sim_next;
    logic ovf_reg, ovf_next;

    logic q_we, d_we, f_we;
    logic [wgis_pkg::Q_AW-1:0] w_raddr;
    logic [31:0] qc_rdata, dc_rdata;
    logic [15:0] qw_rdata;
    logic [0:0] f_rdata;
    logic signed [63:0] p64;

    wgis_ram #(.WIDTH(32), .DEPTH(wgis_pkg::Q_DEPTH)) u_qc_ram (
        .clk(clk), .we(q_we), .waddr(qcnt_reg[wgis_pkg::Q_AW-1:0]), .wdata(cmd.concept),
        .raddr(k_reg[wgis_pkg::Q_AW-1:0]), .rdata(qc_rdata)
    );

    wgis_ram #(.WIDTH(16), .DEPTH(wgis_pkg::Q_DEPTH)) u_qw_ram (
        .clk(clk), .we(q_we), .waddr(qcnt_reg[wgis_pkg::Q_AW-1:0]), .wdata(cmd.weight),
        .raddr(w_raddr), .rdata(qw_rdata)
    );

    wgis_ram #(.WIDTH(1), .DEPTH(wgis_pkg::Q_DEPTH)) u_found_ram (
        .clk(clk), .we(f_we), .waddr(k_reg[wgis_pkg::Q_AW-1:0]), .wdata(found_reg),
        .raddr(jm_reg[wgis_pkg::Q_AW-1:0]), .rdata(f_rdata)
    );

    wgis_ram #(.WIDTH(32), .DEPTH(wgis_pkg::D_DEPTH)) u_dc_ram (
        .clk(clk), .we(d_we), .waddr(dcnt_reg[wgis_pkg::D_AW-1:0]), .wdata(cmd.concept),
        .raddr(jd_reg[wgis_pkg::D_AW-1:0]), .rdata(dc_rdata)
    );

    assign w_raddr = (state_reg == S_I_RD) ? i_reg[wgis_pkg::Q_AW-1:0]
                                           : jm_reg[wgis_pkg::Q_AW-1:0];
    assign cmd_pop = (state_reg == S_IDLE);
    assign q_we = cmd_pop && cmd_valid && (cmd.kind == wgis_pkg::OP_QLOAD)
                  && (qcnt_reg != wgis_pkg::Q_CW'(wgis_pkg::Q_DEPTH));
    assign d_we = cmd_pop && cmd_valid && (cmd.kind == wgis_pkg::OP_DLOAD)
                  && (dcnt_reg != wgis_pkg::D_CW'(wgis_pkg::D_DEPTH));
    assign f_we = (state_reg == S_J_RD) && (jd_reg == dcnt_reg);
    assign p64 = {{(64 - wgis_pkg::PROD_W){prod_reg[wgis_pkg::PROD_W-1]}}, prod_reg};

    assign out_valid = out_valid_reg;
    assign similarity = sim_reg;
    assign overflowed = ovf_reg;

    always_comb
    begin
        state_next = state_reg;
        qcnt_next = qcnt_reg;
        dcnt_next = dcnt_reg;
        drop_next = drop_reg;
        k_next = k_reg;
        i_next = i_reg;
        jm_next = jm_reg;
        jd_next = jd_reg;
        found_next = found_reg;
        first_next = first_reg;
        incl_next = incl_reg;
        qc_next = qc_reg;
        wi_next = wi_reg;
        sum_next = sum_reg;
        prod_next = prod_reg;
        sim_next = sim_reg;
        ovf_next = ovf_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == wgis_pkg::OP_QLOAD)
                    begin
                        if (q_we)
                        begin
                            qcnt_next = qcnt_reg + 1'b1;
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    else if (cmd.kind == wgis_pkg::OP_DLOAD)
                    begin
                        if (d_we)
                        begin
                            dcnt_next = dcnt_reg + 1'b1;
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    else
                    begin
                        k_next = '0;
                        sum_next = '0;
                        state_next = S_K_RD;
                    end
                end
            end
            S_K_RD:
            begin
                if (k_reg == qcnt_reg)
                begin
                    i_next = '0;
                    state_next = S_I_RD;
                end
                else
                begin
                    state_next = S_K_LAT;
                end
            end
            S_K_LAT:
            begin
                qc_next = qc_rdata;
                jd_next = '0;
                found_next = 1'b0;
                state_next = S_J_RD;
            end
            S_J_RD:
            begin
                if (jd_reg == dcnt_reg)
                begin
                    k_next = k_reg + 1'b1;
                    state_next = S_K_RD;
                end
                else
                begin
                    state_next = S_J_CMP;
                end
            end
            S_J_CMP:
            begin
                if (dc_rdata == qc_reg)
                begin
                    found_next = 1'b1;
                end
                jd_next = jd_reg + 1'b1;
                state_next = S_J_RD;
            end
            S_I_RD:
            begin
                if (i_reg == qcnt_reg)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_I_LAT;
                end
            end
            S_I_LAT:
            begin
                wi_next = qw_rdata;
                jm_next = '0;
                first_next = 1'b1;
                incl_next = 1'b1;
                state_next = S_M_RD;
            end
            S_M_RD:
            begin
                if (jm_reg == qcnt_reg)
                begin
                    if (first_reg && incl_reg)
                    begin
                        sum_next = sum_reg
                            + {{(wgis_pkg::SUM_W - 16){wi_reg[15]}}, wi_reg};
                    end
                    i_next = i_reg + 1'b1;
                    state_next = S_I_RD;
                end
                else
                begin
                    state_next = S_M_CMP;
                end
            end
            S_M_CMP:
            begin
                if ($signed(qw_rdata) == wi_reg)
                begin
                    if (jm_reg < i_reg)
                    begin
                        first_next = 1'b0;
                    end
                    if (!f_rdata[0])
                    begin
                        incl_next = 1'b0;
                    end
                end
                jm_next = jm_reg + 1'b1;
                state_next = S_M_RD;
            end
            S_MUL:
            begin
                prod_next = wgis_pkg::PROD_W'(sum_reg) * wgis_pkg::PROD_W'(tw);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (p64 > wgis_pkg::SIM_MAX)
                    begin
                        sim_next = wgis_pkg::SIM_MAX[39:0];
                    end
                    else if (p64 < wgis_pkg::SIM_MIN)
                    begin
                        sim_next = wgis_pkg::SIM_MIN[39:0];
                    end
                    else
                    begin
                        sim_next = p64[39:0];
                    end
                    ovf_next = drop_reg;
                    qcnt_next = '0;
                    dcnt_next = '0;
                    drop_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            qcnt_reg <= '0;
            dcnt_reg <= '0;
            drop_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            qcnt_reg <= qcnt_next;
            dcnt_reg <= dcnt_next;
            drop_reg <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        i_reg <= i_next;
        jm_reg <= jm_next;
        jd_reg <= jd_next;
        found_reg <= found_next;
        first_reg <= first_next;
        incl_reg <= incl_next;
        qc_reg <= qc_next;
        wi_reg <= wi_next;
        sum_reg <= sum_next;
        prod_reg <= prod_next;
        sim_reg <= sim_next;
        ovf_reg <= ovf_next;
    end

`ifndef SYNTHESIS
    a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg <= wgis_pkg::Q_CW'(wgis_pkg::Q_DEPTH))
        else $error("query count beyond capacity");
    a_dcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= wgis_pkg::D_CW'(wgis_pkg::D_DEPTH))
        else $error("document count beyond capacity");
    a_out_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(state_reg == S_OUT))
        else $error("result raised outside evaluate");
    a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && (!out_valid_reg || !out_stall))
        |=> (qcnt_reg == '0 && dcnt_reg == '0 && !drop_reg))
        else $error("stores not cleared after evaluate");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/weight_group_inclusion_similarity.sv =====
// Top level of the weight-group inclusion similarity block.
`timescale 1ns / 1ps
`default_nettype none
// Loads of query terms and document concepts are queued two deep ahead of the
// execution unit. An evaluate walks both stores through one read port each, and
// meanwhile further input transfers queue and then stall. The result register
// lets the next item enter while a result waits.
module weight_group_inclusion_similarity (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         opcode,
    input  wire logic [31:0]        concept_id,
    input  wire logic signed [15:0] term_weight,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [39:0]      similarity,
    output logic                    overflowed,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic signed [15:0] type_weight
);

    logic signed [15:0] tw_reg;
    logic cmd_valid, cmd_pop;
    wgis_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_reg <= wgis_pkg::TW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tw_reg <= type_weight;
        end
    end

    wgis_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .concept_id(concept_id), .term_weight(term_weight),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
    );

    wgis_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
        .tw(tw_reg), .out_valid(out_valid), .out_stall(out_stall),
        .similarity(similarity), .overflowed(overflowed)
    );

endmodule
`default_nettype wire
